[design/can_consumption_range_decoder_defines.svh]
// Assertion macros for the consumption and range decoder.
// Used by the top level only; no other dependencies.
`ifndef CAN_CONSUMPTION_RANGE_DECODER_DEFINES_SVH
`define CAN_CONSUMPTION_RANGE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define CCRD_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error("check failed");
`define CCRD_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error("check failed");
`else
`define CCRD_ASSERT(label, cond)
`define CCRD_ASSERT_IMPL(label, pre, post)
`endif
`endif

[design/ccrd_pkg.sv]
// Shared types and constants of the consumption and range decoder.
// No dependencies.
package ccrd_pkg;
	localparam int AVG_DEPTH = 5;
	localparam logic [1:0] FUNC_CAN = 2'd0;
	localparam logic [1:0] FUNC_FUEL = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_RESERVED = 2'd3;
	localparam logic [10:0] ID_RATE = 11'h362;
	localparam logic [10:0] ID_FAULT = 11'h338;
	localparam logic [10:0] ID_ENGINE = 11'h1D0;
	localparam logic [10:0] ID_SPEED = 11'h1B4;
	localparam logic [15:0] FAULT_IGNORED = 16'd25;
	localparam logic [9:0] INST_LIMIT = 10'd990;
	localparam int RP_W = $clog2(AVG_DEPTH + 1);

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE, OP_LOAD, OP_DIV_START, OP_DIV_STEP, OP_BCD_START, OP_BCD_STEP
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] div_sel;  // 0 range, 1 instantaneous, 2 average
		logic [1:0] bcd_sel;  // 0 rate, 1 average, 2 range
	} cmd_t;

	typedef struct packed {
		logic is_rate;
		logic is_engine;
		logic div_done;
		logic bcd_done;
	} sts_t;

	localparam logic [1:0] DSEL_RANGE = 2'd0;
	localparam logic [1:0] DSEL_INST = 2'd1;
	localparam logic [1:0] DSEL_AVG = 2'd2;
	localparam logic [1:0] BSEL_RATE = 2'd0;
	localparam logic [1:0] BSEL_AVG = 2'd1;
	localparam logic [1:0] BSEL_RANGE = 2'd2;

	function automatic logic [6:0] pair_value(input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = b[7:4];
		lo = b[3:0];
		if (hi > 4'd9) return 7'd0;
		if (lo > 4'd9) return {3'd0, hi};
		return 7'(hi * 4'd10) + {3'd0, lo};
	endfunction
endpackage

[design/ccrd_datapath.sv]
// Datapath: held state, serial restoring divider and serial BCD converter.
// Depends on ccrd_pkg.
module ccrd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ccrd_pkg::cmd_t cmd,
	output ccrd_pkg::sts_t sts,
	input  logic [1:0] func,
	input  logic [10:0] can_id,
	input  logic [7:0] byte0, byte1, byte2, byte3, byte4, byte5,
	output logic [15:0] consumption_now_bcd,
	output logic [15:0] consumption_avg_bcd,
	output logic [15:0] range_bcd,
	output logic [19:0] range_km,
	output logic range_valid,
	output logic flat_tyre_warning,
	output logic tyre_pressure_warning
);
	logic [11:0] rate_q;
	logic [13:0] fuel_q;
	logic signed [16:0] speed_q;
	logic [15:0] inj_q;
	logic [9:0] ring_q [ccrd_pkg::AVG_DEPTH];
	logic [ccrd_pkg::RP_W-1:0] pos_q;
	logic [13:0] sum_q;
	logic [13:0] avg_q;
	logic [19:0] km_q;
	logic valid_q;
	logic [1:0] flags_q;
	logic [15:0] delta_q;
	logic [1:0] func_q;
	logic [10:0] id_q;
	// divider
	logic [23:0] quo_q;
	logic [16:0] rem_q;
	logic [16:0] dvs_q;
	logic [4:0] dcnt_q;
	logic [1:0] dsel_q;
	// bcd (double dabble), six digits so the range keeps its low four
	logic [19:0] bin_q;
	logic [23:0] bcd_q;
	logic [4:0] bcnt_q;
	logic [1:0] bsel_q;

	logic [17:0] trial;
	logic [23:0] adj;
	logic [9:0] inst;

	assign trial = {rem_q, quo_q[23]} - {1'b0, dvs_q};
	assign sts.is_rate = (func_q == ccrd_pkg::FUNC_CAN) && (id_q == ccrd_pkg::ID_RATE);
	assign sts.is_engine = (func_q == ccrd_pkg::FUNC_CAN) && (id_q == ccrd_pkg::ID_ENGINE);
	assign sts.div_done = (dcnt_q == 5'd0);
	assign sts.bcd_done = (bcnt_q == 5'd0);
	assign inst = (speed_q <= 17'sd0) ? 10'd0 :
		((quo_q > 24'(ccrd_pkg::INST_LIMIT)) ? ccrd_pkg::INST_LIMIT : quo_q[9:0]);

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			adj[i*4 +: 4] = (bcd_q[i*4 +: 4] > 4'd4) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			fuel_q <= '0;
			speed_q <= '0;
			inj_q <= '0;
			for (int i = 0; i < ccrd_pkg::AVG_DEPTH; i++) ring_q[i] <= '0;
			pos_q <= '0;
			sum_q <= '0;
			avg_q <= '0;
			km_q <= '0;
			valid_q <= 1'b0;
			flags_q <= '0;
			dcnt_q <= '0;
			bcnt_q <= '0;
			consumption_now_bcd <= '0;
			consumption_avg_bcd <= '0;
			range_bcd <= 16'hFFFF;
		end else begin
			case (cmd.op)
				ccrd_pkg::OP_LOAD: begin
					// latch the item and apply the simple updates
					func_q <= func;
					id_q <= can_id;
					if (func == ccrd_pkg::FUNC_CAN) begin
						if (can_id == ccrd_pkg::ID_RATE) begin
							rate_q <= 12'({byte2, 4'd0} + {8'd0, byte1[7:4]});
						end else if (can_id == ccrd_pkg::ID_FAULT) begin
							if ({byte1, byte0} != ccrd_pkg::FAULT_IGNORED) begin
								if ({byte1, byte0} == 16'd336 || {byte1, byte0} == 16'd63 ||
									{byte1, byte0} == 16'd142 || {byte1, byte0} == 16'd147 ||
									{byte1, byte0} == 16'd265) flags_q[0] <= 1'b1;
								if ({byte1, byte0} == 16'd149 || {byte1, byte0} == 16'd144 ||
									{byte1, byte0} == 16'd145 || {byte1, byte0} == 16'd50 ||
									{byte1, byte0} == 16'd73) flags_q[1] <= 1'b1;
							end
						end else if (can_id == ccrd_pkg::ID_ENGINE) begin
							delta_q <= {byte5, byte4} - inj_q;
							inj_q <= {byte5, byte4};
						end else if (can_id == ccrd_pkg::ID_SPEED) begin
							speed_q <= 17'(($signed({9'd0, byte1}) - 17'sd208) * 17'sd256)
								+ $signed({9'd0, byte0});
						end
					end else if (func == ccrd_pkg::FUNC_FUEL) begin
						fuel_q <= 14'(ccrd_pkg::pair_value(byte3) * 7'd100)
							+ {7'd0, ccrd_pkg::pair_value(byte2)};
					end else if (func == ccrd_pkg::FUNC_CLEAR) begin
						flags_q <= '0;
					end
				end
				ccrd_pkg::OP_DIV_START: begin
					dsel_q <= cmd.div_sel;
					dcnt_q <= 5'd24;
					rem_q <= '0;
					case (cmd.div_sel)
						ccrd_pkg::DSEL_RANGE: begin
							quo_q <= 24'(fuel_q * 7'd100);
							dvs_q <= {5'd0, rate_q};
						end
						ccrd_pkg::DSEL_INST: begin
							quo_q <= 24'(delta_q * 7'd100);
							dvs_q <= speed_q[16] ? 17'd1 : speed_q;
						end
						default: begin
							quo_q <= {10'd0, sum_q};
							dvs_q <= 17'(ccrd_pkg::AVG_DEPTH);
						end
					endcase
				end
				ccrd_pkg::OP_DIV_STEP: begin
					if (dcnt_q != 5'd0) begin
						if (!trial[17]) begin
							rem_q <= trial[16:0];
							quo_q <= {quo_q[22:0], 1'b1};
						end else begin
							rem_q <= {rem_q[15:0], quo_q[23]};
							quo_q <= {quo_q[22:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 5'd1;
					end else begin
						// commit the quotient
						case (dsel_q)
							ccrd_pkg::DSEL_RANGE: begin
								if (rate_q == '0) begin
									km_q <= '0;
									valid_q <= 1'b0;
								end else begin
									km_q <= quo_q[19:0];
									valid_q <= 1'b1;
								end
							end
							ccrd_pkg::DSEL_INST: begin
								sum_q <= sum_q - {4'd0, ring_q[pos_q]} + {4'd0, inst};
								ring_q[pos_q] <= inst;
								pos_q <= (pos_q == ccrd_pkg::RP_W'(ccrd_pkg::AVG_DEPTH - 1)) ?
									'0 : pos_q + 1'b1;
							end
							// hold the average until the next engine frame
							ccrd_pkg::DSEL_AVG: avg_q <= quo_q[13:0];
							default: ;
						endcase
					end
				end
				ccrd_pkg::OP_BCD_START: begin
					bsel_q <= cmd.bcd_sel;
					bcnt_q <= 5'd20;
					bcd_q <= '0;
					case (cmd.bcd_sel)
						ccrd_pkg::BSEL_RATE: bin_q <= {8'd0, rate_q};
						ccrd_pkg::BSEL_AVG: bin_q <= {6'd0, avg_q};
						default: bin_q <= km_q;
					endcase
				end
				ccrd_pkg::OP_BCD_STEP: begin
					if (bcnt_q != 5'd0) begin
						bcd_q <= {adj[22:0], bin_q[19]};
						bin_q <= {bin_q[18:0], 1'b0};
						bcnt_q <= bcnt_q - 5'd1;
					end else begin
						// keep the low four digits
						case (bsel_q)
							ccrd_pkg::BSEL_RATE: consumption_now_bcd <= bcd_q[15:0];
							ccrd_pkg::BSEL_AVG: consumption_avg_bcd <= bcd_q[15:0];
							default: range_bcd <= valid_q ? bcd_q[15:0] : 16'hFFFF;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	assign range_km = valid_q ? km_q : '0;
	assign range_valid = valid_q;
	assign flat_tyre_warning = flags_q[0];
	assign tyre_pressure_warning = flags_q[1];
endmodule

[design/ccrd_ctrl.sv]
// Controller: sequences load, divisions and BCD conversions per item.
// Depends on ccrd_pkg.
module ccrd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_fire,
	input  ccrd_pkg::sts_t sts,
	output ccrd_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_RDIV_GO, S_RDIV, S_IDIV_GO, S_IDIV, S_ADIV_GO, S_ADIV,
		S_B0_GO, S_B0, S_B1_GO, S_B1, S_B2_GO, S_B2, S_OUT
	} state_t;
	state_t state_q;

	always_comb begin
		cmd = '{op: ccrd_pkg::OP_NONE, div_sel: ccrd_pkg::DSEL_RANGE, bcd_sel: ccrd_pkg::BSEL_RATE};
		case (state_q)
			S_IDLE: if (in_fire) cmd.op = ccrd_pkg::OP_LOAD;
			S_RDIV_GO: cmd = '{ccrd_pkg::OP_DIV_START, ccrd_pkg::DSEL_RANGE, ccrd_pkg::BSEL_RATE};
			S_IDIV_GO: cmd = '{ccrd_pkg::OP_DIV_START, ccrd_pkg::DSEL_INST, ccrd_pkg::BSEL_RATE};
			S_ADIV_GO: cmd = '{ccrd_pkg::OP_DIV_START, ccrd_pkg::DSEL_AVG, ccrd_pkg::BSEL_RATE};
			S_RDIV, S_IDIV, S_ADIV: cmd.op = ccrd_pkg::OP_DIV_STEP;
			S_B0_GO: cmd = '{ccrd_pkg::OP_BCD_START, ccrd_pkg::DSEL_RANGE, ccrd_pkg::BSEL_RATE};
			S_B1_GO: cmd = '{ccrd_pkg::OP_BCD_START, ccrd_pkg::DSEL_RANGE, ccrd_pkg::BSEL_AVG};
			S_B2_GO: cmd = '{ccrd_pkg::OP_BCD_START, ccrd_pkg::DSEL_RANGE, ccrd_pkg::BSEL_RANGE};
			S_B0, S_B1, S_B2: cmd.op = ccrd_pkg::OP_BCD_STEP;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_LOAD;
				S_LOAD: begin
					if (sts.is_rate) state_q <= S_RDIV_GO;
					else if (sts.is_engine) state_q <= S_IDIV_GO;
					else state_q <= S_B0_GO;
				end
				S_RDIV_GO: state_q <= S_RDIV;
				S_RDIV: if (sts.div_done) state_q <= S_B0_GO;
				S_IDIV_GO: state_q <= S_IDIV;
				S_IDIV: if (sts.div_done) state_q <= S_ADIV_GO;
				S_ADIV_GO: state_q <= S_ADIV;
				S_ADIV: if (sts.div_done) state_q <= S_B0_GO;
				S_B0_GO: state_q <= S_B0;
				S_B0: if (sts.bcd_done) state_q <= S_B1_GO;
				S_B1_GO: state_q <= S_B1;
				S_B1: if (sts.bcd_done) state_q <= S_B2_GO;
				S_B2_GO: state_q <= S_B2;
				S_B2: if (sts.bcd_done) state_q <= S_OUT;
				S_OUT: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[design/can_consumption_range_decoder.sv]
// Consumption and range decoder, top level: stream ports, controller, datapath.
// Depends on ccrd_pkg, ccrd_ctrl, ccrd_datapath and the defines header.
//
// Takes one item at a time and returns one result item per input item.
// m_tvalid rises once the divisions, if any, and the BCD conversions are done;
// with m_tready high the controller returns to idle, and the next item can
// then be accepted.
// A 24-step serial restoring divider (range for a rate frame; instantaneous
// consumption, then the ring average, for an engine frame; each with start and
// commit) and a 20-step serial BCD converter, run three times, do the arithmetic.
// s_tready is low from acceptance until the result item is taken.
`include "can_consumption_range_decoder_defines.svh"
module can_consumption_range_decoder (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: can_id[10:0], byte0..byte5 [58:11], zero [63:59]
	input  logic [63:0] s_tdata,
	// tuser: func[1:0]
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: consumption_now_bcd, consumption_avg_bcd, range_bcd, range_km,
	// range_valid, flat_tyre_warning, tyre_pressure_warning, zero [87:71]
	output logic [87:0] m_tdata
);
	ccrd_pkg::cmd_t cmd;
	ccrd_pkg::sts_t sts;
	logic busy;
	logic in_fire, out_fire;
	logic [15:0] now_bcd, avg_bcd, rng_bcd;
	logic [19:0] km;
	logic rv, ftw, tpw;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	ccrd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	ccrd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(s_tuser), .can_id(s_tdata[10:0]),
		.byte0(s_tdata[18:11]), .byte1(s_tdata[26:19]), .byte2(s_tdata[34:27]),
		.byte3(s_tdata[42:35]), .byte4(s_tdata[50:43]), .byte5(s_tdata[58:51]),
		.consumption_now_bcd(now_bcd), .consumption_avg_bcd(avg_bcd),
		.range_bcd(rng_bcd), .range_km(km), .range_valid(rv),
		.flat_tyre_warning(ftw), .tyre_pressure_warning(tpw)
	);

	assign m_tdata = {17'd0, tpw, ftw, rv, km, rng_bcd, avg_bcd, now_bcd};

	// never accept while a result is pending
	`CCRD_ASSERT(a_no_accept_when_valid, !(m_tvalid && s_tready))
	// an accepted item leads to the busy sequence
	`CCRD_ASSERT_IMPL(a_busy_after_accept, in_fire, !s_tready)
	// invalid range shows blank BCD and zero km
	`CCRD_ASSERT(a_invalid_range, !(m_tvalid && !rv) || (rng_bcd == 16'hFFFF && km == 20'd0))
endmodule

[tb/can_consumption_range_decoder_tb.sv]
// Self-checking testbench of the consumption and range decoder.
// Drives frames, fuel reports and fault clears, and predicts every result item.
// Depends on ccrd_pkg and the can_consumption_range_decoder top level.
module can_consumption_range_decoder_tb;

	typedef struct packed {
		logic [1:0] func;
		logic [10:0] can_id;
		logic [7:0] b0, b1, b2, b3, b4, b5;
	} frame_t;

	// lowest field last, matching the result tdata layout
	typedef struct packed {
		logic press;
		logic flat;
		logic valid;
		logic [19:0] range_km;
		logic [15:0] range_bcd;
		logic [15:0] avg_bcd;
		logic [15:0] now_bcd;
	} readout_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [87:0] m_tdata;

	can_consumption_range_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// vehicle state as the decoder should hold it
	logic [11:0] rate_q;
	logic [13:0] fuel_q;
	int speed_q;
	logic [15:0] inj_q;
	logic [9:0] ring_q [ccrd_pkg::AVG_DEPTH];
	int ring_idx;
	logic [12:0] ring_total;
	logic [19:0] range_q;
	logic range_ok_q;
	logic flat_q, press_q;

	frame_t pending_frames [$];
	readout_t expected_readouts [$];
	int errors = 0;
	int send_idle_pct, recv_stall_pct;
	bit hold_recv;
	bit done;
	bit accepted_now;
	int cycles = 0;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic [15:0] bcd4(input int v);
		return {4'((v / 1000) % 10), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
	endfunction

	function automatic int bcd_pair(input logic [7:0] b);
		if (b[7:4] > 9) return 0;
		if (b[3:0] > 9) return b[7:4];
		return b[7:4] * 10 + b[3:0];
	endfunction

	// advance the predicted state by one item and return the readout it gives
	function automatic readout_t decode_frame(input frame_t f);
		readout_t r;
		int fid, now, delta, inst;
		if (f.func == ccrd_pkg::FUNC_CAN) begin
			if (f.can_id == ccrd_pkg::ID_RATE) begin
				rate_q = {f.b2, f.b1[7:4]};
				range_ok_q = (rate_q != 0);
				range_q = range_ok_q ? 20'((100 * fuel_q) / rate_q) : 20'd0;
			end else if (f.can_id == ccrd_pkg::ID_FAULT) begin
				fid = {f.b1, f.b0};
				if (fid != ccrd_pkg::FAULT_IGNORED) begin
					if (fid inside {336, 63, 142, 147, 265}) flat_q = 1'b1;
					if (fid inside {149, 144, 145, 50, 73}) press_q = 1'b1;
				end
			end else if (f.can_id == ccrd_pkg::ID_ENGINE) begin
				now = {f.b5, f.b4};
				delta = (now + 65536 - inj_q) % 65536;
				inj_q = now;
				inst = 0;
				if (speed_q > 0) begin
					inst = (100 * delta) / speed_q;
					if (inst > ccrd_pkg::INST_LIMIT) inst = ccrd_pkg::INST_LIMIT;
				end
				ring_total = ring_total - ring_q[ring_idx] + 13'(inst);
				ring_q[ring_idx] = 10'(inst);
				ring_idx = (ring_idx + 1) % ccrd_pkg::AVG_DEPTH;
			end else if (f.can_id == ccrd_pkg::ID_SPEED) begin
				speed_q = (int'(f.b1) - 'hD0) * 256 + int'(f.b0);
			end
		end else if (f.func == ccrd_pkg::FUNC_FUEL) begin
			fuel_q = 14'(bcd_pair(f.b3) * 100 + bcd_pair(f.b2));
		end else if (f.func == ccrd_pkg::FUNC_CLEAR) begin
			flat_q = 1'b0;
			press_q = 1'b0;
		end
		r.now_bcd = bcd4(rate_q);
		r.avg_bcd = bcd4(ring_total / ccrd_pkg::AVG_DEPTH);
		r.range_bcd = range_ok_q ? bcd4(range_q) : 16'hFFFF;
		r.range_km = range_ok_q ? range_q : 20'd0;
		r.valid = range_ok_q;
		r.flat = flat_q;
		r.press = press_q;
		return r;
	endfunction

	function automatic frame_t make_frame(input logic [1:0] func, input logic [10:0] id,
			input logic [7:0] b0, b1, b2, b3, b4, b5);
		frame_t f;
		f.func = func; f.can_id = id;
		f.b0 = b0; f.b1 = b1; f.b2 = b2; f.b3 = b3; f.b4 = b4; f.b5 = b5;
		return f;
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] bcd_byte();
		return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
	endfunction

	// mostly well-formed frames with live content; a share of noise
	function automatic frame_t random_frame();
		int pick;
		logic [10:0] id;
		logic [7:0] b0, b1;
		pick = $urandom_range(0, 99);
		b0 = rnd8(); b1 = rnd8();
		if (pick < 14) begin
			id = ccrd_pkg::ID_SPEED;
			// mostly small positive speeds, sometimes zero or negative
			case ($urandom_range(0, 5))
				0: b1 = 8'($urandom_range(0, 8'hCF));
				1: begin b1 = 8'hD0; b0 = 8'($urandom_range(0, 3)); end
				default: b1 = 8'($urandom_range(8'hD0, 8'hD3));
			endcase
		end else if (pick < 36) id = ccrd_pkg::ID_ENGINE;
		else if (pick < 50) id = ccrd_pkg::ID_RATE;
		else if (pick < 62) begin
			id = ccrd_pkg::ID_FAULT;
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 10))
					0: {b1, b0} = 16'd336; 1: {b1, b0} = 16'd63;
					2: {b1, b0} = 16'd142; 3: {b1, b0} = 16'd147;
					4: {b1, b0} = 16'd265; 5: {b1, b0} = 16'd149;
					6: {b1, b0} = 16'd144; 7: {b1, b0} = 16'd145;
					8: {b1, b0} = 16'd50; 9: {b1, b0} = 16'd73;
					default: {b1, b0} = ccrd_pkg::FAULT_IGNORED;
				endcase
			end
		end else if (pick < 72) id = 11'($urandom);
		else id = 11'd0;
		if (pick < 72) begin
			return make_frame(ccrd_pkg::FUNC_CAN, id, b0, b1, rnd8(), rnd8(), rnd8(), rnd8());
		end else if (pick < 88) begin
			if ($urandom_range(0, 3) == 0)
				return make_frame(ccrd_pkg::FUNC_FUEL, 11'($urandom), b0, b1, rnd8(), rnd8(),
					rnd8(), rnd8());
			return make_frame(ccrd_pkg::FUNC_FUEL, 11'($urandom), b0, b1, bcd_byte(),
				bcd_byte(), rnd8(), rnd8());
		end else if (pick < 95) begin
			return make_frame(ccrd_pkg::FUNC_CLEAR, 11'($urandom), b0, b1, rnd8(), rnd8(),
				rnd8(), rnd8());
		end
		return make_frame(ccrd_pkg::FUNC_RESERVED, 11'($urandom), b0, b1, rnd8(), rnd8(),
			rnd8(), rnd8());
	endfunction

	// note each acceptance at the rising edge where it happens
	always @(posedge clk) accepted_now <= arst_n && s_tvalid && s_tready;

	// driver: offer the head of the pending queue, change inputs at the falling edge;
	// hold an offered item until it is taken
	always @(negedge clk) begin
		if (accepted_now) begin
			expected_readouts.push_back(decode_frame(pending_frames.pop_front()));
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (pending_frames.size() != 0 && ((s_tvalid && !accepted_now) ||
				($urandom_range(0, 99) >= send_idle_pct))) begin
			s_tvalid <= 1'b1;
			s_tdata <= {5'd0, pending_frames[0].b5, pending_frames[0].b4,
				pending_frames[0].b3, pending_frames[0].b2, pending_frames[0].b1,
				pending_frames[0].b0, pending_frames[0].can_id};
			s_tuser <= pending_frames[0].func;
		end else begin
			s_tvalid <= 1'b0;
		end
		m_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// monitor: compare each result item with the oldest expectation
	always @(posedge clk) begin
		readout_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[70:0];
			if (expected_readouts.size() == 0) begin
				$error("result item with no expectation: %h", got);
				errors++;
			end else begin
				want = expected_readouts.pop_front();
				if (got.now_bcd !== want.now_bcd) begin
					$error("consumption_now_bcd exp %h got %h", want.now_bcd, got.now_bcd);
					errors++;
				end
				if (got.avg_bcd !== want.avg_bcd) begin
					$error("consumption_avg_bcd exp %h got %h", want.avg_bcd, got.avg_bcd);
					errors++;
				end
				if (got.range_bcd !== want.range_bcd) begin
					$error("range_bcd exp %h got %h", want.range_bcd, got.range_bcd);
					errors++;
				end
				if (got.range_km !== want.range_km) begin
					$error("range_km exp %0d got %0d", want.range_km, got.range_km);
					errors++;
				end
				if (got.valid !== want.valid) begin
					$error("range_valid exp %b got %b", want.valid, got.valid);
					errors++;
				end
				if (got.flat !== want.flat) begin
					$error("flat_tyre_warning exp %b got %b", want.flat, got.flat);
					errors++;
				end
				if (got.press !== want.press) begin
					$error("tyre_pressure_warning exp %b got %b", want.press, got.press);
					errors++;
				end
			end
		end
	end

	// watchdog: slowest run is about 1700 items plus stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000 && !done) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_frames.size() != 0 || expected_readouts.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	initial begin
		int k;
		done = 0; hold_recv = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		rate_q = '0; fuel_q = '0; speed_q = 0; inj_q = '0;
		foreach (ring_q[i]) ring_q[i] = '0;
		ring_idx = 0; ring_total = '0; range_q = '0; range_ok_q = 0;
		flat_q = 0; press_q = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: zero rate, extremes, non-BCD fuel, faults, speed edge cases
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_RATE,
			0, 0, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_FUEL, 0, 0, 0, 8'h99, 8'h99, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_RATE,
			0, 8'h10, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_RATE,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_FUEL, 11'h7FF, 8'hFF, 8'hFF,
			8'hA5, 8'h5C, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_RATE,
			0, 8'h50, 8'h03, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_ENGINE,
			0, 0, 0, 0, 8'h10, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_SPEED,
			8'hFF, 8'hCF, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_ENGINE,
			0, 0, 0, 0, 8'h20, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_SPEED,
			8'h01, 8'hD0, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_ENGINE,
			0, 0, 0, 0, 8'hFF, 8'hFF));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_SPEED,
			8'hFF, 8'hFF, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_ENGINE,
			0, 0, 0, 0, 8'h05, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_FAULT,
			8'd25, 0, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_FAULT,
			8'h50, 8'h01, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_FAULT,
			8'd73, 0, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, ccrd_pkg::ID_FAULT,
			8'hFF, 8'hFF, 0, 0, 0, 0));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CAN, 11'h7FF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_RESERVED, 11'h7FF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_frames.push_back(make_frame(ccrd_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		wait_drained();

		// random phases: free flow, idle sender, stalling receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 35) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 35) : 0;
			for (k = 0; k < 400; k++) pending_frames.push_back(random_frame());
			if (ph == 2) begin
				// hold the receiver off for a long stretch while items keep coming
				hold_recv = 1;
				repeat (600) @(posedge clk);
				hold_recv = 0;
			end
			// sender pauses until all results are back
			wait_drained();
		end
		send_idle_pct = 0; recv_stall_pct = 0;
		for (k = 0; k < 80; k++) pending_frames.push_back(random_frame());
		wait_drained();
		repeat (200) @(posedge clk);
		done = 1;
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
